// File: sv/gdeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdeq_pkg
// Shared types and constants for the gamepad deadzone and edge qualifier.
// ----------------------------------------------------------------------------
package gdeq_pkg;

	localparam int USER_SLOTS_DEF   = 4;
	localparam int BUTTON_COUNT_DEF = 14;

	localparam int BTN_W  = 14;
	localparam int TRIG_W = 8;
	localparam int DZ_W   = 15;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DZ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LSTICK_DZ  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RSTICK_DZ  = 2'd2;

	localparam logic [TRIG_W-1:0] TRIGGER_DZ_RST = 8'd30;
	localparam logic [DZ_W-1:0]   LSTICK_DZ_RST  = 15'd7849;
	localparam logic [DZ_W-1:0]   RSTICK_DZ_RST  = 15'd8689;

	localparam logic [15:0] TRIGGER_FULL = 16'd255;
	localparam logic [15:0] STICK_FULL   = 16'd32767;
	localparam logic [14:0] AXIS_FULL    = 15'd32767;

	// divider: 15 quotient bits, DIV_BITS per cycle
	localparam int QUO_W     = 15;
	localparam int DIV_BITS  = 3;
	localparam int DIV_STEPS = QUO_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// axis sequence codes
	localparam int AXIS_COUNT = 6;
	localparam logic [2:0] AX_LT = 3'd0;
	localparam logic [2:0] AX_RT = 3'd1;
	localparam logic [2:0] AX_LX = 3'd2;
	localparam logic [2:0] AX_LY = 3'd3;
	localparam logic [2:0] AX_RX = 3'd4;
	localparam logic [2:0] AX_RY = 3'd5;

	typedef struct packed {
		logic [1:0]         user;
		logic               connected;
		logic [15:0]        button_word;
		logic [TRIG_W-1:0]  left_trigger_raw;
		logic [TRIG_W-1:0]  right_trigger_raw;
		logic signed [15:0] left_x_raw;
		logic signed [15:0] left_y_raw;
		logic signed [15:0] right_x_raw;
		logic signed [15:0] right_y_raw;
	} gdeq_in_t;

	typedef struct packed {
		logic [1:0]         user_out;
		logic [BTN_W-1:0]   buttons_down;
		logic [BTN_W-1:0]   buttons_pressed;
		logic [BTN_W-1:0]   buttons_released;
		logic [14:0]        left_trigger_axis;
		logic [14:0]        right_trigger_axis;
		logic signed [15:0] left_x_axis;
		logic signed [15:0] left_y_axis;
		logic signed [15:0] right_x_axis;
		logic signed [15:0] right_y_axis;
	} gdeq_out_t;

endpackage

// File: sv/gdeq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdeq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gdeq_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 4,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/gamepad_deadzone_edge_qualifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_deadzone_edge_qualifier_unit
// Button edge detection against a per-slot history RAM, plus deadzone removal
// and rescaling of two triggers and four stick axes through a shared divider.
// ----------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// sample   | in  | sample_valid/stall   | gdeq_in_t  (one polled sample)
// result   | out | result_valid/stall   | gdeq_out_t (one result per sample)
// cfg      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (deadzones)
//
// One sample at a time: accept, history read, edge/write-back, then six axes
// when connected. Each axis passes through S_SETUP, then through S_DIV when a
// division is needed; a disconnected sample goes from S_EDGE to S_DONE. The
// divider is a radix-8 restoring divider.
// Reset clears the history valid bits and loads the default deadzones.
// A stalled result stays in its output register while the next sample runs.
// ----------------------------------------------------------------------------
module gamepad_deadzone_edge_qualifier_unit #(
	parameter int USER_SLOTS   = gdeq_pkg::USER_SLOTS_DEF,
	parameter int BUTTON_COUNT = gdeq_pkg::BUTTON_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  gdeq_pkg::gdeq_in_t                  sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output gdeq_pkg::gdeq_out_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gdeq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gdeq_pkg::DZ_W-1:0]           cfg_data
);

	import gdeq_pkg::*;

	localparam int SLOT_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
	localparam int KEEP_W = (BUTTON_COUNT > BTN_W) ? BTN_W : BUTTON_COUNT;
	localparam logic [BTN_W:0] KEEP_FULL = ((BTN_W + 1)'(1) << KEEP_W) - (BTN_W + 1)'(1);
	localparam logic [BTN_W-1:0] KEEP_MASK = KEEP_FULL[BTN_W-1:0];
	localparam logic [4:0] SLOTS5 = 5'(USER_SLOTS);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EDGE  = 5'b00010,
		S_SETUP = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [TRIG_W-1:0] trig_dz_q;
	logic [DZ_W-1:0]   lstick_dz_q;
	logic [DZ_W-1:0]   rstick_dz_q;

	gdeq_in_t          smp_q;
	logic [SLOT_W-1:0] slot_q;
	logic              prev_vld_q;
	logic [USER_SLOTS-1:0] vld_q;

	gdeq_out_t res_q;
	gdeq_out_t result_q;
	logic      result_valid_q;

	logic [2:0]           axis_q;
	logic [14:0]          rem_q;
	logic [14:0]          dvd_lo_q;
	logic [14:0]          quo_q;
	logic [14:0]          dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;

	logic sample_acc;
	logic result_free;
	assign sample_acc   = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE);
	assign result_free  = !result_valid_q || !result_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// slot index wraps modulo USER_SLOTS
	logic [4:0]        slot_w;
	logic [SLOT_W-1:0] slot_d;
	always_comb begin
		slot_w = {3'b000, sample.user};
		for (int i = 0; i < 3; i++) begin
			if (slot_w >= SLOTS5) begin
				slot_w = slot_w - SLOTS5;
			end
		end
		slot_d = slot_w[SLOT_W-1:0];
	end

	// history RAM
	logic [KEEP_W-1:0] hist_rd;
	logic [BTN_W-1:0]  down_d;
	logic [BTN_W-1:0]  prev_d;

	gdeq_ram #(
		.WIDTH (KEEP_W),
		.DEPTH (USER_SLOTS)
	) u_hist (
		.clk     (clk),
		.wr_en   (state_q == S_EDGE),
		.wr_addr (slot_q),
		.wr_data (down_d[KEEP_W-1:0]),
		.rd_en   (sample_acc),
		.rd_addr (slot_d),
		.rd_data (hist_rd)
	);

	always_comb begin
		down_d = 14'd0;
		if (smp_q.connected) begin
			down_d = {smp_q.button_word[15:12], smp_q.button_word[9:0]} & KEEP_MASK;
		end
		prev_d = prev_vld_q ? BTN_W'(hist_rd) : 14'd0;
	end

	// axis setup: magnitude, deadzone and full scale of the current axis
	logic [15:0] su_raw;
	logic [15:0] su_mag;
	logic [15:0] su_dz;
	logic [15:0] su_full;
	logic        su_neg;
	logic        su_zero;
	logic        su_sat;
	logic [15:0] su_diff;
	logic [29:0] su_dvd;
	logic [15:0] su_dvs;
	always_comb begin
		su_raw  = 16'd0;
		su_neg  = 1'b0;
		su_dz   = {1'b0, lstick_dz_q};
		su_full = STICK_FULL;
		case (axis_q)
			AX_LT: su_raw = {8'd0, smp_q.left_trigger_raw};
			AX_RT: su_raw = {8'd0, smp_q.right_trigger_raw};
			AX_LX: su_raw = smp_q.left_x_raw;
			AX_LY: su_raw = smp_q.left_y_raw;
			AX_RX: su_raw = smp_q.right_x_raw;
			AX_RY: su_raw = smp_q.right_y_raw;
			default: su_raw = 16'd0;
		endcase
		if (axis_q == AX_LT || axis_q == AX_RT) begin
			su_dz   = {8'd0, trig_dz_q};
			su_full = TRIGGER_FULL;
		end else begin
			su_neg = su_raw[15];
			if (axis_q == AX_RX || axis_q == AX_RY) begin
				su_dz = {1'b0, rstick_dz_q};
			end
		end
		su_mag  = su_neg ? (16'd0 - su_raw) : su_raw;
		su_zero = (su_mag <= su_dz);
		su_sat  = (su_mag >= su_full);
		su_diff = su_mag - su_dz;
		// diff * 32767 as a shift and subtract
		su_dvd  = {su_diff[14:0], 15'd0} - {15'd0, su_diff[14:0]};
		su_dvs  = su_full - su_dz;
	end

	// restoring divider, DIV_BITS quotient bits per cycle
	logic [15:0] dv_rem;
	logic [14:0] dv_lo;
	logic [14:0] dv_quo;
	always_comb begin
		dv_rem = {1'b0, rem_q};
		dv_lo  = dvd_lo_q;
		dv_quo = quo_q;
		for (int b = 0; b < DIV_BITS; b++) begin
			dv_rem = {dv_rem[14:0], dv_lo[14]};
			dv_lo  = {dv_lo[13:0], 1'b0};
			if (dv_rem >= {1'b0, dvs_q}) begin
				dv_rem = dv_rem - {1'b0, dvs_q};
				dv_quo = {dv_quo[13:0], 1'b1};
			end else begin
				dv_quo = {dv_quo[13:0], 1'b0};
			end
		end
	end

	// value written back for the current axis
	logic        ax_wr;
	logic [14:0] ax_mag;
	logic        ax_neg;
	logic [15:0] ax_val;
	logic        div_last;
	assign div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	always_comb begin
		ax_wr  = 1'b0;
		ax_mag = 15'd0;
		ax_neg = 1'b0;
		if (state_q == S_SETUP && (su_zero || su_sat)) begin
			ax_wr  = 1'b1;
			ax_mag = su_zero ? 15'd0 : AXIS_FULL;
			ax_neg = su_neg;
		end else if (state_q == S_DIV && div_last) begin
			ax_wr  = 1'b1;
			ax_mag = dv_quo;
			ax_neg = neg_q;
		end
		ax_val = ax_neg ? (16'd0 - {1'b0, ax_mag}) : {1'b0, ax_mag};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			vld_q          <= '0;
			trig_dz_q      <= TRIGGER_DZ_RST;
			lstick_dz_q    <= LSTICK_DZ_RST;
			rstick_dz_q    <= RSTICK_DZ_RST;
			axis_q         <= AX_LT;
			cnt_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TRIGGER_DZ: trig_dz_q   <= cfg_data[TRIG_W-1:0];
					REG_LSTICK_DZ:  lstick_dz_q <= cfg_data;
					REG_RSTICK_DZ:  rstick_dz_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && result_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample_acc) begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					vld_q[slot_q] <= 1'b1;
					axis_q        <= AX_LT;
					state_q       <= smp_q.connected ? S_SETUP : S_DONE;
				end
				S_SETUP: begin
					cnt_q <= '0;
					if (su_zero || su_sat) begin
						axis_q <= axis_q + 3'd1;
						if (axis_q == 3'(AXIS_COUNT - 1)) begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						axis_q  <= axis_q + 3'd1;
						state_q <= (axis_q == 3'(AXIS_COUNT - 1)) ? S_DONE : S_SETUP;
					end
				end
				S_DONE: begin
					if (result_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			smp_q      <= sample;
			slot_q     <= slot_d;
			prev_vld_q <= vld_q[slot_d];
		end
		if (state_q == S_EDGE) begin
			res_q.user_out         <= smp_q.user;
			res_q.buttons_down     <= down_d;
			res_q.buttons_pressed  <= down_d & ~prev_d;
			res_q.buttons_released <= prev_d & ~down_d;
			// a disconnected sample leaves every axis at zero
			res_q.left_trigger_axis  <= 15'd0;
			res_q.right_trigger_axis <= 15'd0;
			res_q.left_x_axis        <= 16'sd0;
			res_q.left_y_axis        <= 16'sd0;
			res_q.right_x_axis       <= 16'sd0;
			res_q.right_y_axis       <= 16'sd0;
		end
		if (state_q == S_SETUP) begin
			rem_q    <= su_dvd[29:15];
			dvd_lo_q <= su_dvd[14:0];
			dvs_q    <= su_dvs[14:0];
			quo_q    <= 15'd0;
			neg_q    <= su_neg;
		end
		if (state_q == S_DIV) begin
			rem_q    <= dv_rem[14:0];
			dvd_lo_q <= dv_lo;
			quo_q    <= dv_quo;
		end
		if (ax_wr) begin
			case (axis_q)
				AX_LT: res_q.left_trigger_axis  <= ax_val[14:0];
				AX_RT: res_q.right_trigger_axis <= ax_val[14:0];
				AX_LX: res_q.left_x_axis        <= ax_val;
				AX_LY: res_q.left_y_axis        <= ax_val;
				AX_RX: res_q.right_x_axis       <= ax_val;
				AX_RY: res_q.right_y_axis       <= ax_val;
				default: ;
			endcase
		end
		if (state_q == S_DONE && result_free) begin
			result_q <= res_q;
		end
	end

endmodule

// File: tb/tb_gamepad_deadzone_edge_qualifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_deadzone_edge_qualifier_unit
// Self-checking bench: drives controller samples, keeps a per-slot model of
// button history and axis rescaling, and checks every result against it over
// several deadzone settings, with random result stalls and random sample gaps.
// ----------------------------------------------------------------------------

class gamepad_result_scoreboard;
	logic [13:0]         last_down [4];
	logic [7:0]          trig_dz;
	logic [14:0]         lstick_dz;
	logic [14:0]         rstick_dz;
	gdeq_pkg::gdeq_out_t awaited_results [$];
	int                  errors;

	function new();
		foreach (last_down[i]) last_down[i] = '0;
		trig_dz   = gdeq_pkg::TRIGGER_DZ_RST;
		lstick_dz = gdeq_pkg::LSTICK_DZ_RST;
		rstick_dz = gdeq_pkg::RSTICK_DZ_RST;
		errors    = 0;
	endfunction

	function void set_deadzone(logic [1:0] idx, logic [14:0] data);
		case (idx)
		gdeq_pkg::REG_TRIGGER_DZ: trig_dz = data[7:0];
		gdeq_pkg::REG_LSTICK_DZ:  lstick_dz = data;
		gdeq_pkg::REG_RSTICK_DZ:  rstick_dz = data;
		default: ;
		endcase
	endfunction

	static function logic [14:0] rescale(int unsigned mag, int unsigned dz, int unsigned full);
		if (mag <= dz)
			return '0;
		if (mag >= full)
			return gdeq_pkg::AXIS_FULL;
		return 15'((longint'(mag - dz) * longint'(gdeq_pkg::AXIS_FULL)) / longint'(full - dz));
	endfunction

	static function logic [15:0] stick_q15(logic [15:0] raw, int unsigned dz);
		int unsigned mag;
		logic [15:0] v;
		// -32768 has magnitude 32768
		mag = raw[15] ? (32'h10000 - raw) : raw;
		v = {1'b0, rescale(mag, dz, gdeq_pkg::STICK_FULL)};
		if (raw[15])
			v = 16'(17'h10000 - v);
		return v;
	endfunction

	function void note_sample(gdeq_pkg::gdeq_in_t s);
		gdeq_pkg::gdeq_out_t r;
		logic [13:0] down;
		logic [13:0] prev;
		prev = last_down[s.user];
		// bits 0x400 and 0x800 of the raw word are not buttons
		down = s.connected ? {s.button_word[15:12], s.button_word[9:0]} : '0;
		r = '0;
		r.user_out         = s.user;
		r.buttons_down     = down;
		r.buttons_pressed  = down & ~prev;
		r.buttons_released = prev & ~down;
		if (s.connected) begin
			r.left_trigger_axis  = rescale(s.left_trigger_raw, trig_dz, gdeq_pkg::TRIGGER_FULL);
			r.right_trigger_axis = rescale(s.right_trigger_raw, trig_dz, gdeq_pkg::TRIGGER_FULL);
			r.left_x_axis  = stick_q15(s.left_x_raw, lstick_dz);
			r.left_y_axis  = stick_q15(s.left_y_raw, lstick_dz);
			r.right_x_axis = stick_q15(s.right_x_raw, rstick_dz);
			r.right_y_axis = stick_q15(s.right_y_raw, rstick_dz);
		end
		last_down[s.user] = down;
		awaited_results.push_back(r);
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(gdeq_pkg::gdeq_out_t got);
		gdeq_pkg::gdeq_out_t want;
		if (awaited_results.size() == 0) begin
			$error("result transaction with no sample outstanding");
			errors++;
			return;
		end
		want = awaited_results.pop_front();
		compare_field("user_out", want.user_out, got.user_out);
		compare_field("buttons_down", want.buttons_down, got.buttons_down);
		compare_field("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
		compare_field("buttons_released", want.buttons_released, got.buttons_released);
		compare_field("left_trigger_axis", want.left_trigger_axis, got.left_trigger_axis);
		compare_field("right_trigger_axis", want.right_trigger_axis, got.right_trigger_axis);
		compare_field("left_x_axis", $signed(want.left_x_axis), $signed(got.left_x_axis));
		compare_field("left_y_axis", $signed(want.left_y_axis), $signed(got.left_y_axis));
		compare_field("right_x_axis", $signed(want.right_x_axis), $signed(got.right_x_axis));
		compare_field("right_y_axis", $signed(want.right_y_axis), $signed(got.right_y_axis));
	endfunction
endclass

module tb_gamepad_deadzone_edge_qualifier_unit;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	gdeq_pkg::gdeq_in_t  sample = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	gdeq_pkg::gdeq_out_t result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [14:0]         cfg_data = '0;

	gamepad_result_scoreboard sb = new();

	logic [15:0] word_by_user [4] = '{default: '0};
	bit          steady_run = 1'b0;
	int          quiet_cycles = 0;
	int          samples_sent = 0;
	int          samples_dropped = 0;
	int          results_seen = 0;
	int          reg_writes = 0;
	int          settings_used = 1;

	gamepad_deadzone_edge_qualifier_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: check and stall at random
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
			results_seen++;
		end
		result_stall <= !steady_run && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_gamepad_deadzone_edge_qualifier_unit: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic gdeq_pkg::gdeq_in_t mk(logic [1:0] u, logic c, logic [15:0] w,
			logic [7:0] lt, logic [7:0] rt, int lx, int ly, int rx, int ry);
		gdeq_pkg::gdeq_in_t s;
		s.user = u;
		s.connected = c;
		s.button_word = w;
		s.left_trigger_raw = lt;
		s.right_trigger_raw = rt;
		s.left_x_raw = 16'(lx);
		s.left_y_raw = 16'(ly);
		s.right_x_raw = 16'(rx);
		s.right_y_raw = 16'(ry);
		return s;
	endfunction

	function automatic logic [7:0] rand_trigger(int unsigned dz);
		int v;
		case ($urandom_range(0, 5))
		0: v = 0;
		1: v = 255;
		2: v = int'(dz) + int'($urandom_range(0, 4)) - 2;
		default: v = $urandom_range(0, 255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic logic [15:0] rand_stick(int unsigned dz);
		int  m;
		logic neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
		0: m = 0;
		1: m = 32767;
		2: m = 32768;
		3: m = int'(dz) + int'($urandom_range(0, 4)) - 2;
		4: m = int'(dz) + int'($urandom_range(0, 200)) - 100;
		default: m = $urandom_range(0, 32768);
		endcase
		if (m < 0)
			m = 0;
		if (m > 32768)
			m = 32768;
		if (!neg && m > 32767)
			m = 32767;
		return neg ? 16'(-m) : 16'(m);
	endfunction

	// mostly small changes to the slot's last word so that edges stay sparse
	function automatic logic [15:0] next_buttons(logic [1:0] u);
		logic [15:0] w;
		case ($urandom_range(0, 9))
		0: w = 16'h0000;
		1: w = 16'hFFFF;
		2, 3: w = 16'($urandom);
		default: begin
			w = word_by_user[u] ^ (16'h1 << $urandom_range(0, 15));
			if ($urandom_range(0, 1))
				w = w ^ (16'h1 << $urandom_range(0, 15));
		end
		endcase
		word_by_user[u] = w;
		return w;
	endfunction

	function automatic gdeq_pkg::gdeq_in_t random_sample();
		gdeq_pkg::gdeq_in_t s;
		s.user = 2'($urandom_range(0, 3));
		s.connected = ($urandom_range(0, 9) != 0);
		s.button_word = next_buttons(s.user);
		s.left_trigger_raw = rand_trigger(sb.trig_dz);
		s.right_trigger_raw = rand_trigger(sb.trig_dz);
		s.left_x_raw = rand_stick(sb.lstick_dz);
		s.left_y_raw = rand_stick(sb.lstick_dz);
		s.right_x_raw = rand_stick(sb.rstick_dz);
		s.right_y_raw = rand_stick(sb.rstick_dz);
		return s;
	endfunction

	task automatic push_sample(input gdeq_pkg::gdeq_in_t s);
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(s);
		samples_sent++;
		if (!s.connected)
			samples_dropped++;
		if (!steady_run && $urandom_range(0, 99) < 31) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 45 : 8))
				@(posedge clk);
		end
	endtask

	task automatic run_random(input int n);
		repeat (n)
			push_sample(random_sample());
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_deadzone(idx, data);
		reg_writes++;
	endtask

	task automatic apply_setting(input logic [14:0] trig, input logic [14:0] lstick,
			input logic [14:0] rstick, input bit touch_spare);
		drain();
		repeat (4)
			@(posedge clk);
		if (touch_spare)
			write_reg(REG_SPARE, 15'($urandom));
		write_reg(gdeq_pkg::REG_TRIGGER_DZ, trig);
		write_reg(gdeq_pkg::REG_LSTICK_DZ, lstick);
		write_reg(gdeq_pkg::REG_RSTICK_DZ, rstick);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset deadzones: trigger 30, left 7849, right 8689
		push_sample(mk(0, 1, 16'h0000, 0, 0, 0, 0, 0, 0));
		push_sample(mk(0, 1, 16'hFFFF, 255, 255, 32767, -32768, 32767, -32768));
		push_sample(mk(0, 1, 16'h0C00, 30, 31, 7849, -7849, 8689, -8689));
		push_sample(mk(0, 1, 16'hF3FF, 254, 1, 7850, -7850, 8690, -8690));
		push_sample(mk(0, 0, 16'hFFFF, 255, 255, -1, 1, 32767, -32768));
		push_sample(mk(0, 1, 16'h0001, 0, 255, -32767, 32766, 1, -1));
		push_sample(mk(1, 1, 16'h5555, 128, 29, 16000, -16000, 20000, -20000));
		push_sample(mk(1, 1, 16'hAAAA, 31, 200, 7848, -7848, 8688, -8688));
		push_sample(mk(2, 1, 16'h1000, 100, 100, 32766, -32767, 32766, -32767));
		push_sample(mk(3, 0, 16'h0000, 255, 0, 100, -100, 100, -100));
		push_sample(mk(3, 1, 16'h8000, 255, 255, -32768, 32767, -32768, 32767));
		push_sample(mk(2, 1, 16'hF000, 0, 30, 0, 0, 0, 0));
		push_sample(mk(1, 0, 16'h3FF0, 77, 88, 9999, -9999, 9999, -9999));
		push_sample(mk(3, 1, 16'h03FF, 254, 254, 20000, 25000, -25000, -20000));
		push_sample(mk(3, 1, 16'h03FF, 129, 64, 1, 2, -2, -1));
		run_random(120);

		// no deadzone at all, with a stretch of full-rate traffic
		apply_setting(15'd0, 15'd0, 15'd0, 1'b0);
		steady_run = 1'b1;
		run_random(80);
		steady_run = 1'b0;
		run_random(20);

		// deadzones at or just below full scale; upper data bits land above the 8-bit trigger field
		apply_setting(15'h7FFF, 15'd32767, 15'd32766, 1'b0);
		run_random(80);

		apply_setting(15'd254, 15'($urandom_range(0, 32766)), 15'($urandom_range(0, 32766)), 1'b1);
		run_random(60);
		drain();
		run_random(60);

		apply_setting(15'($urandom), 15'($urandom), 15'($urandom), 1'b0);
		run_random(160);

		drain();
		repeat (60)
			@(posedge clk);
		$display("covered %0d samples (%0d disconnected), %0d results checked",
			samples_sent, samples_dropped, results_seen);
		$display("over %0d deadzone settings with %0d register writes", settings_used, reg_writes);
		if (sb.errors == 0 && sb.awaited_results.size() == 0)
			$display("tb_gamepad_deadzone_edge_qualifier_unit: PASS");
		else
			$display("tb_gamepad_deadzone_edge_qualifier_unit: FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/gdeq_pkg.sv
sv/gdeq_ram.sv
sv/gamepad_deadzone_edge_qualifier_unit.sv
tb/tb_gamepad_deadzone_edge_qualifier_unit.sv
